FILE: rtl/cau_pkg.sv
package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW = 32;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int NW = SW - 1;
    localparam int QW = 41;
    localparam int DIV_STEPS = NW + FRAC_BITS;
    localparam int SQ_STEPS = DW;
    localparam int PIPE = DIV_STEPS + 4;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MAG = 3'd4;
    localparam logic [2:0] OP_CONJ = 3'd5;
    localparam logic [2:0] OP_EQ = 3'd6;

    typedef struct packed {
        logic neg;
        logic [NW:0] mag;
    } smag_t;

    typedef struct packed {
        logic sat;
        logic [DW-1:0] val;
    } clamp_t;

    function automatic clamp_t clamp_sm(input logic neg, input logic [NW:0] mag);
        clamp_t r;
        r.sat = 1'b0;
        if (!neg && mag > (NW+1)'(32'h7fff_ffff)) begin
            r.sat = 1'b1;
            r.val = 32'h7fff_ffff;
        end else if (neg && mag > (NW+1)'(33'h0_8000_0000)) begin
            r.sat = 1'b1;
            r.val = 32'h8000_0000;
        end else if (neg) begin
            r.val = DW'(~mag + 1'b1);
        end else begin
            r.val = mag[DW-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/cau_divider.sv
module cau_divider
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [cau_pkg::NW-1:0]       num,
    input  logic [cau_pkg::PW-1:0]       den,
    output logic [cau_pkg::QW-1:0]       quo
);

    localparam int N = cau_pkg::DIV_STEPS;
    localparam int RW = cau_pkg::PW + 1;
    localparam int QW = cau_pkg::QW;
    localparam int NW = cau_pkg::NW;

    logic [RW-1:0] rem_reg [N+1];
    logic [QW-1:0] q_reg   [N+1];
    logic [NW-1:0] n_reg   [N+1];
    logic [cau_pkg::PW-1:0] d_reg [N+1];
    logic          v_reg   [N+1];

    always_comb
    begin
        rem_reg[0] = '0;
        q_reg[0] = '0;
        n_reg[0] = num;
        d_reg[0] = den;
        v_reg[0] = in_valid;
    end

    // restoring division, one quotient bit per stage, quotient held once its bit 40 is set
    for (genvar i = 0; i < N; i++) begin : g_step
        logic [RW:0] sh;
        logic        bit_in;
        logic        ge;
        logic [QW-1:0] qn;
        logic        capped;
        assign bit_in = (i < NW) ? n_reg[i][NW-1] : 1'b0;
        assign sh = {rem_reg[i], bit_in};
        assign ge = sh >= {1'b0, 1'b0, d_reg[i]};
        assign capped = q_reg[i][QW-1];
        assign qn = capped ? q_reg[i] : {q_reg[i][QW-2:0], ge};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (v_reg[i])
            begin
                rem_reg[i+1] <= ge ? RW'(sh - {2'b0, d_reg[i]}) : sh[RW-1:0];
                q_reg[i+1] <= qn;
                n_reg[i+1] <= {n_reg[i][NW-2:0], 1'b0};
                d_reg[i+1] <= d_reg[i];
            end
        end
    end

    assign quo = q_reg[N];

endmodule

FILE: rtl/cau_sqrt.sv
module cau_sqrt
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [cau_pkg::PW-1:0]   rad,
    output logic [cau_pkg::DW-1:0]   root
);

    localparam int N = cau_pkg::SQ_STEPS;
    localparam int PW = cau_pkg::PW;
    localparam int DW = cau_pkg::DW;

    logic [PW-1:0] x_reg [N+1];
    logic [DW+1:0] rem_reg [N+1];
    logic [DW-1:0] r_reg [N+1];
    logic          v_reg [N+1];

    always_comb
    begin
        x_reg[0] = rad;
        rem_reg[0] = '0;
        r_reg[0] = '0;
        v_reg[0] = in_valid;
    end

    // digit-by-digit root, one result bit per stage
    for (genvar i = 0; i < N; i++) begin : g_step
        logic [DW+1:0] t;
        logic [DW+1:0] trial;
        logic          ok;
        assign t = {rem_reg[i][DW-1:0], x_reg[i][PW-1:PW-2]};
        assign trial = {r_reg[i], 2'b01};
        assign ok = t >= trial;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (v_reg[i])
            begin
                x_reg[i+1] <= {x_reg[i][PW-3:0], 2'b00};
                rem_reg[i+1] <= ok ? t - trial : t;
                r_reg[i+1] <= {r_reg[i][DW-2:0], ok};
            end
        end
    end

    assign root = r_reg[N];

endmodule

FILE: rtl/complex_arithmetic_unit_core.sv
// throughput: one item per cycle; busy stays low, results cannot be held off
// the divider and square root are bit-per-stage pipelines; others are delay matched
// reset: rst_n clears all valid bits asynchronously; payload registers are not reset
module complex_arithmetic_unit_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   op,
    input  logic signed [31:0]           a_re,
    input  logic signed [31:0]           a_im,
    input  logic signed [31:0]           b_re,
    input  logic signed [31:0]           b_im,
    output logic                         valid,
    output logic signed [31:0]           res_re,
    output logic signed [31:0]           res_im,
    output logic                         is_equal,
    output logic                         div_zero,
    output logic                         saturated
);

    localparam int DW = cau_pkg::DW;
    localparam int PW = cau_pkg::PW;
    localparam int NW = cau_pkg::NW;
    localparam int F = cau_pkg::FRAC_BITS;
    localparam int D = cau_pkg::DIV_STEPS;

    assign busy = 1'b0;

    // stage 1: products, equality compare and add/sub/conjugate sums
    logic          v1_reg;
    logic [2:0]    op1_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;
    logic [PW-1:0] sq_br_reg, sq_bi_reg, sq_ar_reg, sq_ai_reg;
    logic          eq1_reg;
    logic signed [DW:0] sum_re1_reg, sum_im1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        op1_reg <= op;
        p_rr_reg <= a_re * b_re;
        p_ii_reg <= a_im * b_im;
        p_ir_reg <= a_im * b_re;
        p_ri_reg <= a_re * b_im;
        sq_br_reg <= b_re * b_re;
        sq_bi_reg <= b_im * b_im;
        sq_ar_reg <= a_re * a_re;
        sq_ai_reg <= a_im * a_im;
        eq1_reg <= (a_re == b_re) && (a_im == b_im);
        case (op)
            cau_pkg::OP_ADD:
            begin
                sum_re1_reg <= a_re + b_re;
                sum_im1_reg <= a_im + b_im;
            end
            cau_pkg::OP_SUB:
            begin
                sum_re1_reg <= a_re - b_re;
                sum_im1_reg <= a_im - b_im;
            end
            default:
            begin
                sum_re1_reg <= (DW+1)'(a_re);
                sum_im1_reg <= -(DW+1)'(a_im);
            end
        endcase
    end

    // stage 2: sums of products
    logic          v2_reg;
    logic [2:0]    op2_reg;
    logic signed [PW:0] mre_reg, mim_reg, nre_reg, nim_reg;
    logic [PW:0]   den_reg, mag2_reg;
    logic          eq2_reg;
    logic signed [DW:0] sum_re2_reg, sum_im2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        op2_reg <= op1_reg;
        mre_reg <= (PW+1)'(p_rr_reg) - (PW+1)'(p_ii_reg);
        mim_reg <= (PW+1)'(p_ir_reg) + (PW+1)'(p_ri_reg);
        nre_reg <= (PW+1)'(p_rr_reg) + (PW+1)'(p_ii_reg);
        nim_reg <= (PW+1)'(p_ir_reg) - (PW+1)'(p_ri_reg);
        den_reg <= {1'b0, sq_br_reg} + {1'b0, sq_bi_reg};
        mag2_reg <= {1'b0, sq_ar_reg} + {1'b0, sq_ai_reg};
        eq2_reg <= eq1_reg;
        sum_re2_reg <= sum_re1_reg;
        sum_im2_reg <= sum_im1_reg;
    end

    // stage 3: sign/magnitude split, product scaling, clamping of simple ops
    logic          v3_reg;
    logic [2:0]    op3_reg;
    logic          nre_neg_reg, nim_neg_reg, dz3_reg, eq3_reg;
    logic [NW-1:0] nre_mag_reg, nim_mag_reg;
    logic [PW-1:0] den3_reg, mag3_reg;
    cau_pkg::clamp_t cre3_reg, cim3_reg;

    logic signed [PW:0] mre_fl, mim_fl;
    logic [NW:0] a_mre, a_mim, a_nre, a_nim, a_sre, a_sim;
    cau_pkg::clamp_t cre_next, cim_next;

    always_comb
    begin
        mre_fl = mre_reg >>> F;
        mim_fl = mim_reg >>> F;
        a_sre = (NW+1)'(sum_re2_reg[DW] ? -sum_re2_reg : sum_re2_reg);
        a_sim = (NW+1)'(sum_im2_reg[DW] ? -sum_im2_reg : sum_im2_reg);
        a_mre = (NW+1)'(mre_fl[PW] ? -mre_fl : mre_fl);
        a_mim = (NW+1)'(mim_fl[PW] ? -mim_fl : mim_fl);
        a_nre = (NW+1)'(nre_reg[PW] ? -nre_reg : nre_reg);
        a_nim = (NW+1)'(nim_reg[PW] ? -nim_reg : nim_reg);
        case (op2_reg)
            cau_pkg::OP_MUL:
            begin
                cre_next = cau_pkg::clamp_sm(mre_fl[PW], a_mre);
                cim_next = cau_pkg::clamp_sm(mim_fl[PW], a_mim);
            end
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_CONJ:
            begin
                cre_next = cau_pkg::clamp_sm(sum_re2_reg[DW], a_sre);
                cim_next = cau_pkg::clamp_sm(sum_im2_reg[DW], a_sim);
            end
            default:
            begin
                cre_next = '0;
                cim_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        op3_reg <= op2_reg;
        nre_neg_reg <= nre_reg[PW];
        nim_neg_reg <= nim_reg[PW];
        nre_mag_reg <= a_nre[NW-1:0];
        nim_mag_reg <= a_nim[NW-1:0];
        den3_reg <= den_reg[PW-1:0];
        dz3_reg <= den_reg == '0;
        mag3_reg <= mag2_reg[PW-1:0];
        eq3_reg <= eq2_reg;
        cre3_reg <= cre_next;
        cim3_reg <= cim_next;
    end

    // long stages: divider and square root, control delayed alongside
    logic [cau_pkg::QW-1:0] q_re, q_im;
    logic [DW-1:0] root;
    logic go_div, go_sq;

    assign go_div = v3_reg && op3_reg == cau_pkg::OP_DIV && !dz3_reg;
    assign go_sq = v3_reg && op3_reg == cau_pkg::OP_MAG;

    cau_divider u_div_re
    (
        .clk(clk), .rst_n(rst_n), .in_valid(go_div),
        .num(nre_mag_reg), .den(den3_reg), .quo(q_re)
    );

    cau_divider u_div_im
    (
        .clk(clk), .rst_n(rst_n), .in_valid(go_div),
        .num(nim_mag_reg), .den(den3_reg), .quo(q_im)
    );

    cau_sqrt u_sqrt
    (
        .clk(clk), .rst_n(rst_n), .in_valid(go_sq),
        .rad(mag3_reg), .root(root)
    );

    typedef struct packed {
        logic            v;
        logic [2:0]      op;
        logic            nre_neg;
        logic            nim_neg;
        logic            dz;
        logic            eq;
        cau_pkg::clamp_t cre;
        cau_pkg::clamp_t cim;
    } ctl_t;

    ctl_t ctl_reg [D+1];
    logic [DW-1:0] root_reg;

    always_comb
    begin
        ctl_reg[0].v = v3_reg;
        ctl_reg[0].op = op3_reg;
        ctl_reg[0].nre_neg = nre_neg_reg;
        ctl_reg[0].nim_neg = nim_neg_reg;
        ctl_reg[0].dz = dz3_reg;
        ctl_reg[0].eq = eq3_reg;
        ctl_reg[0].cre = cre3_reg;
        ctl_reg[0].cim = cim3_reg;
    end

    for (genvar i = 0; i < D; i++) begin : g_dly
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[i+1].v <= 1'b0;
            else
                ctl_reg[i+1] <= ctl_reg[i];
        end
    end

    // square root finishes earlier; hold it until the divider latency is reached
    logic [DW-1:0] rdly_reg [D-cau_pkg::SQ_STEPS+1];
    always_comb rdly_reg[0] = root;
    for (genvar i = 0; i < D - cau_pkg::SQ_STEPS; i++) begin : g_rdly
        always_ff @(posedge clk)
        begin
            rdly_reg[i+1] <= rdly_reg[i];
        end
    end
    assign root_reg = rdly_reg[D - cau_pkg::SQ_STEPS];

    // final stage
    ctl_t c;
    cau_pkg::clamp_t dre, dim;
    logic valid_reg, valid_next;
    logic [DW-1:0] re_reg, re_next, im_reg, im_next;
    logic eq_reg, eq_next, dz_reg, dz_next, sat_reg, sat_next;

    always_comb
    begin
        c = ctl_reg[D];
        dre = cau_pkg::clamp_sm(c.nre_neg && q_re != '0, (NW+1)'(q_re));
        dim = cau_pkg::clamp_sm(c.nim_neg && q_im != '0, (NW+1)'(q_im));
        valid_next = c.v;
        re_next = '0;
        im_next = '0;
        eq_next = 1'b0;
        dz_next = 1'b0;
        sat_next = 1'b0;
        case (c.op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL, cau_pkg::OP_CONJ:
            begin
                re_next = c.cre.val;
                im_next = c.cim.val;
                sat_next = c.cre.sat | c.cim.sat;
            end
            cau_pkg::OP_DIV:
            begin
                if (c.dz)
                    dz_next = 1'b1;
                else
                begin
                    re_next = dre.val;
                    im_next = dim.val;
                    sat_next = dre.sat | dim.sat;
                end
            end
            cau_pkg::OP_MAG:
            begin
                re_next = root_reg[DW-1] ? 32'h7fff_ffff : root_reg;
                sat_next = root_reg[DW-1];
            end
            cau_pkg::OP_EQ:
            begin
                eq_next = c.eq;
            end
            default:
            begin
                re_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        re_reg <= re_next;
        im_reg <= im_next;
        eq_reg <= eq_next;
        dz_reg <= dz_next;
        sat_reg <= sat_next;
    end

    assign valid = valid_reg;
    assign res_re = re_reg;
    assign res_im = im_reg;
    assign is_equal = eq_reg;
    assign div_zero = dz_reg;
    assign saturated = sat_reg;

endmodule

FILE: rtl/cau_checker.sv
module cau_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        valid,
    input logic [31:0] res_re,
    input logic [31:0] res_im,
    input logic        is_equal,
    input logic        div_zero,
    input logic        saturated
);

    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> !(is_equal && div_zero) && !(div_zero && saturated))
        else $error("conflicting flags");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && div_zero |-> res_re == '0 && res_im == '0)
        else $error("divide by zero result not zero");

    a_eq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && is_equal |-> res_re == '0 && res_im == '0)
        else $error("equal result not zero");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker
(
    .clk(clk), .rst_n(rst_n), .busy(busy), .valid(valid),
    .res_re(res_re), .res_im(res_im), .is_equal(is_equal),
    .div_zero(div_zero), .saturated(saturated)
);

FILE: test/complex_arithmetic_unit_core_test.sv
`timescale 1ns / 100ps

module complex_arithmetic_unit_core_test;

    localparam int FB = cau_pkg::FRAC_BITS;
    localparam logic [2:0] OP_NONE = 3'd7;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        eq;
        logic        dz;
        logic        sat;
    } cplx_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         op;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
    logic               valid;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               is_equal;
    logic               div_zero;
    logic               saturated;

    cplx_result_t expected_results[$];
    int           error_count;

    complex_arithmetic_unit_core dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .a_re(a_re),
        .a_im(a_im),
        .b_re(b_re),
        .b_im(b_im),
        .valid(valid),
        .res_re(res_re),
        .res_im(res_im),
        .is_equal(is_equal),
        .div_zero(div_zero),
        .saturated(saturated)
    );

    always #4 clk = ~clk;

    // saturate a wide signed value to 32 bits
    function automatic logic [31:0] clamp_part(input logic signed [127:0] v, inout logic sat);
        if (v > 128'sh7fff_ffff)
        begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -128'sh8000_0000)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // truncated quotient with magnitude capped at 2^40
    function automatic logic signed [127:0] div_part(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (n < 0) ? -n : n;
        q = (mag << FB) / d;
        if (q > (128'd1 << 40))
            q = 128'd1 << 40;
        return (n < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [63:0] isqrt(input logic [127:0] x);
        logic [63:0] r;
        logic [127:0] t;
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic cplx_result_t predict_cplx(input logic [2:0] o,
                                                  input logic signed [31:0] ar,
                                                  input logic signed [31:0] ai,
                                                  input logic signed [31:0] br,
                                                  input logic signed [31:0] bi);
        cplx_result_t r;
        logic signed [127:0] xr, xi, yr, yi, den;
        logic s;
        xr = ar;
        xi = ai;
        yr = br;
        yi = bi;
        s = 1'b0;
        r = '0;
        case (o)
            cau_pkg::OP_ADD:
            begin
                r.re = clamp_part(xr + yr, s);
                r.im = clamp_part(xi + yi, s);
            end
            cau_pkg::OP_SUB:
            begin
                r.re = clamp_part(xr - yr, s);
                r.im = clamp_part(xi - yi, s);
            end
            cau_pkg::OP_MUL:
            begin
                r.re = clamp_part((xr * yr - xi * yi) >>> FB, s);
                r.im = clamp_part((xi * yr + xr * yi) >>> FB, s);
            end
            cau_pkg::OP_DIV:
            begin
                den = yr * yr + yi * yi;
                if (den == 0)
                    r.dz = 1'b1;
                else
                begin
                    r.re = clamp_part(div_part(xr * yr + xi * yi, den), s);
                    r.im = clamp_part(div_part(xi * yr - xr * yi, den), s);
                end
            end
            cau_pkg::OP_MAG:
                r.re = clamp_part($signed({64'd0, isqrt(xr * xr + xi * xi)}), s);
            cau_pkg::OP_CONJ:
            begin
                r.re = clamp_part(xr, s);
                r.im = clamp_part(-xi, s);
            end
            cau_pkg::OP_EQ:
                r.eq = (ar == br) && (ai == bi);
            default:
                r = '0;
        endcase
        r.sat = s;
        return r;
    endfunction

    task automatic send_item(input logic [2:0] o, input logic [31:0] ar, input logic [31:0] ai,
                             input logic [31:0] br, input logic [31:0] bi);
        op <= o;
        a_re <= ar;
        a_im <= ai;
        b_re <= br;
        b_im <= bi;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        expected_results.push_back(predict_cplx(o, ar, ai, br, bi));
        @(negedge clk);
        if ($urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 3))
                @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        cplx_result_t e;
        if (rst_n && valid)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no item pending: %h %h", $time, res_re, res_im);
                error_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (e != {res_re, res_im, is_equal, div_zero, saturated})
                begin
                    $display("%0t: mismatch expected re=%h im=%h eq=%b dz=%b sat=%b",
                             $time, e.re, e.im, e.eq, e.dz, e.sat);
                    $display("%0t:          actual   re=%h im=%h eq=%b dz=%b sat=%b",
                             $time, res_re, res_im, is_equal, div_zero, saturated);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 3) << 16;
            3: return $signed($urandom_range(0, 'h3ffff)) - 'h20000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] mx, mn;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        for (int o = 0; o < 8; o++)
        begin
            send_item(o[2:0], 32'h0003_0000, 32'hfffe_8000, 32'h0001_4000, 32'h0000_c000);
        end
        send_item(cau_pkg::OP_ADD, mx, mn, mx, mn);
        send_item(cau_pkg::OP_SUB, mn, mx, mx, mn);
        send_item(cau_pkg::OP_MUL, mn, mn, mn, mn);
        send_item(cau_pkg::OP_MUL, mx, mx, mn, mx);
        send_item(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        send_item(cau_pkg::OP_DIV, mx, mn, 32'h0, 32'h1);
        send_item(cau_pkg::OP_DIV, mn, mn, 32'h1, 32'hffff_ffff);
        send_item(cau_pkg::OP_DIV, 32'hffff_ffff, 32'h1, mx, mn);
        send_item(cau_pkg::OP_MAG, mn, mn, 32'h0, 32'h0);
        send_item(cau_pkg::OP_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(cau_pkg::OP_CONJ, mn, mn, 32'h0, 32'h0);
        send_item(cau_pkg::OP_EQ, mx, mn, mx, mn);
        send_item(cau_pkg::OP_EQ, mx, mn, mx, mx);
        send_item(OP_NONE, mx, mn, mx, mn);
    endtask

    task automatic test_random();
        logic [31:0] ar, ai;
        for (int n = 0; n < 600; n++)
        begin
            ar = rand_word();
            ai = rand_word();
            if ($urandom_range(0, 7) == 0)
                send_item(cau_pkg::OP_EQ, ar, ai, ar,
                          ($urandom_range(0, 1) == 0) ? ai : rand_word());
            else
                send_item(3'($urandom_range(0, 7)), ar, ai, rand_word(), rand_word());
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        op = cau_pkg::OP_ADD;
        a_re = '0;
        a_im = '0;
        b_re = '0;
        b_im = '0;
        error_count = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (cau_pkg::PIPE + 10) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
